// ===== src/perlin_noise_2d_macros.svh =====
// Assertion macros for the perlin_noise_2d block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PERLIN_NOISE_2D_MACROS_SVH
`define PERLIN_NOISE_2D_MACROS_SVH

// same-cycle implication
`define PN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pn2d_pkg.sv =====
// Package for the 2-D noise block: fixed-point types, constants, gradient function.
// No dependencies.
`default_nettype none

package pn2d_pkg;

  localparam int Q_BITS = 14;
  localparam int Q_ONE  = 16384;

  // quintic fade 6t^5 - 15t^4 + 10t^3
  localparam int FADE_A = 6;
  localparam int FADE_B = 15;
  localparam int FADE_C = 10;

  localparam int PIX_MAX   = 255;
  localparam int NOISE_MAX = 32767;
  localparam int NOISE_MIN = -32768;

  // gradient selector codes
  localparam logic [3:0] H_U_FROM_Y = 4'd8;
  localparam logic [3:0] H_V_FROM_Y = 4'd4;
  localparam logic [3:0] H_V_X_LO   = 4'd12;
  localparam logic [3:0] H_V_X_HI   = 4'd14;

  typedef logic [13:0]        q14_t;
  typedef logic signed [15:0] offs_t;
  typedef logic signed [17:0] grad_t;
  typedef logic signed [15:0] noise_t;

  function automatic grad_t corner_grad(input logic [3:0] h, input offs_t gx,
                                        input offs_t gy);
    grad_t gu;
    grad_t gv;
    gu = (h < H_U_FROM_Y) ? grad_t'(gx) : grad_t'(gy);
    if (h < H_V_FROM_Y) begin
      gv = grad_t'(gy);
    end else if (h == H_V_X_LO || h == H_V_X_HI) begin
      gv = grad_t'(gx);
    end else begin
      gv = '0;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

endpackage

`default_nettype wire

// ===== src/pn2d_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module pn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ===== src/perlin_noise_2d.sv =====
// 2-D improved noise evaluator; uses pn2d_pkg, pn2d_ram and the macro header.
// An evaluate beat passes the flags ev1_r to ev7_r, then out_tvalid_r; all stall while en is low.
// Throughput: one beat per cycle, loads and evaluates alike, unless the output stalls; a load gives no output.
// Reset: synchronous rst_n clears the stage valid flags; table RAMs keep no reset.
// TABLE_SIZE must be a power of two; the block itself does not enforce this.
`default_nettype none

module perlin_noise_2d
  import pn2d_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] table_index, [15:8] table_value, [35:16] x_coord, [55:36] y_coord
  input  logic [55:0] in_tdata,
  // [0] action
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] noise_value, [23:16] pixel_byte
  output logic [23:0] out_tdata
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int HW = AW + 9;

  logic en;
  logic in_acc;
  logic in_action;
  logic [7:0]  tbl_idx;
  logic [7:0]  tbl_val;
  logic [19:0] coord [2];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign in_action = in_tuser[0];
  assign tbl_idx   = in_tdata[7:0];
  assign tbl_val   = in_tdata[15:8];
  assign coord[0]  = in_tdata[35:16];
  assign coord[1]  = in_tdata[55:36];

  // stage regs
  logic          wr1_r, ev1_r, ev2_r, ev3_r, ev4_r, ev5_r, ev6_r, ev7_r;
  logic          wr1_nxt, ev1_nxt;
  logic [AW-1:0] widx1_r, widx1_nxt;
  logic [7:0]    wval1_r;
  logic [AW-1:0] cy1_r, cy1_nxt;
  q14_t          t1_r [2], t1_nxt [2];
  q14_t          t2_r [2];
  logic signed [33:0] tp2_r [2], tp2_nxt [2];
  logic [27:0]   sq2_r [2], sq2_nxt [2];
  logic [17:0]   s2_3_r [2], s2_3_nxt [2];
  logic [41:0]   cube3_r [2], cube3_nxt [2];
  logic [38:0]   pl4_r [2], pl4_nxt [2];
  logic [38:0]   ph4_r [2], ph4_nxt [2];
  logic [14:0]   fu5_r [2], fu5_nxt [2];
  grad_t         n3_r [4], n3_nxt [4];
  grad_t         n4_r [4];
  grad_t         n5_r [4];
  grad_t         lo6_r, hi6_r, lo6_nxt, hi6_nxt;
  logic [14:0]   fv6_r;
  noise_t        noise7_r, noise7_nxt;
  logic          out_tvalid_r;
  noise_t        noise_o_r;
  logic [7:0]    pix_o_r, pix_nxt;

  // input split
  logic [AW-1:0] cx_in;
  logic [HW-1:0] idx_ext;
  logic [19:0]   cint [2];
  logic [FRAC_BITS+Q_BITS-1:0] fwide [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cint[i]   = coord[i] >> FRAC_BITS;
      fwide[i]  = {coord[i][FRAC_BITS-1:0], {Q_BITS{1'b0}}};
      t1_nxt[i] = fwide[i][FRAC_BITS+Q_BITS-1:FRAC_BITS];
    end
    cx_in     = cint[0][AW-1:0];
    cy1_nxt   = cint[1][AW-1:0];
    idx_ext   = HW'(tbl_idx);
    widx1_nxt = idx_ext[AW-1:0];
    wr1_nxt   = in_acc && !in_action;
    ev1_nxt   = in_acc && in_action;
  end

  // corner and hash tables
  logic [7:0] pa0, pa1, pb0, pb1, pc0, pc1;

  pn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_cell (
    .clk, .we(wr1_nxt), .waddr(widx1_nxt), .wdata(tbl_val), .re(en),
    .raddr0(cx_in), .raddr1(cx_in + AW'(1)), .rdata0(pa0), .rdata1(pa1)
  );

  logic [HW-1:0] ha_sum, hb_sum;
  logic [AW-1:0] ha, hb;

  always_comb begin
    ha_sum = HW'(pa0) + HW'(cy1_r);
    hb_sum = HW'(pa1) + HW'(cy1_r);
    ha     = ha_sum[AW-1:0];
    hb     = hb_sum[AW-1:0];
  end

  pn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_row0 (
    .clk, .we(en && wr1_r), .waddr(widx1_r), .wdata(wval1_r), .re(en),
    .raddr0(ha), .raddr1(hb), .rdata0(pb0), .rdata1(pb1)
  );

  pn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_row1 (
    .clk, .we(en && wr1_r), .waddr(widx1_r), .wdata(wval1_r), .re(en),
    .raddr0(ha + AW'(1)), .raddr1(hb + AW'(1)), .rdata0(pc0), .rdata1(pc1)
  );

  // fade datapath, one lane per axis
  logic signed [18:0] s1 [2];
  logic signed [20:0] s2w [2];
  logic [59:0]        fsum [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s1[i]        = 19'(FADE_A) * $signed({5'b0, t1_r[i]}) - 19'(FADE_B * Q_ONE);
      tp2_nxt[i]   = 34'($signed({1'b0, t1_r[i]})) * 34'(s1[i]);
      sq2_nxt[i]   = 28'(t1_r[i]) * 28'(t1_r[i]);
      s2w[i]       = 21'(tp2_r[i] >>> Q_BITS) + 21'(FADE_C * Q_ONE);
      s2_3_nxt[i]  = s2w[i][17:0];
      cube3_nxt[i] = 42'(sq2_r[i]) * 42'(t2_r[i]);
      pl4_nxt[i]   = 39'(cube3_r[i][20:0]) * 39'(s2_3_r[i]);
      ph4_nxt[i]   = 39'(cube3_r[i][41:21]) * 39'(s2_3_r[i]);
      fsum[i]      = {ph4_r[i], 21'b0} + 60'(pl4_r[i]);
      fu5_nxt[i]   = fsum[i][56:42];
    end
  end

  // corner gradients
  offs_t gx0, gx1, gy0, gy1;

  always_comb begin
    gx0       = $signed({2'b00, t2_r[0]});
    gy0       = $signed({2'b00, t2_r[1]});
    gx1       = gx0 - offs_t'(Q_ONE);
    gy1       = gy0 - offs_t'(Q_ONE);
    n3_nxt[0] = corner_grad(pb0[3:0], gx0, gy0);
    n3_nxt[1] = corner_grad(pb1[3:0], gx1, gy0);
    n3_nxt[2] = corner_grad(pc0[3:0], gx0, gy1);
    n3_nxt[3] = corner_grad(pc1[3:0], gx1, gy1);
  end

  // lerps, saturation, pixel
  logic signed [18:0] dlo, dhi, dv;
  logic signed [34:0] plo, phi, pv;
  grad_t              nfull;
  logic [22:0]        pix_prod;
  logic [8:0]         pix_q;

  always_comb begin
    dlo     = 19'(n5_r[1]) - 19'(n5_r[0]);
    dhi     = 19'(n5_r[3]) - 19'(n5_r[2]);
    plo     = 35'($signed({1'b0, fu5_r[0]})) * 35'(dlo);
    phi     = 35'($signed({1'b0, fu5_r[0]})) * 35'(dhi);
    lo6_nxt = n5_r[0] + grad_t'(plo >>> Q_BITS);
    hi6_nxt = n5_r[2] + grad_t'(phi >>> Q_BITS);

    dv    = 19'(hi6_r) - 19'(lo6_r);
    pv    = 35'($signed({1'b0, fv6_r})) * 35'(dv);
    nfull = lo6_r + grad_t'(pv >>> Q_BITS);
    priority if (nfull > grad_t'(NOISE_MAX)) begin
      noise7_nxt = noise_t'(NOISE_MAX);
    end else if (nfull < grad_t'(NOISE_MIN)) begin
      noise7_nxt = noise_t'(NOISE_MIN);
    end else begin
      noise7_nxt = nfull[15:0];
    end

    pix_prod = {noise7_r[14:0], 8'b0} - {8'b0, noise7_r[14:0]};
    pix_q    = pix_prod[22:14];
    priority if (noise7_r[15] || noise7_r == '0) begin
      pix_nxt = '0;
    end else if (pix_q > 9'(PIX_MAX)) begin
      pix_nxt = 8'(PIX_MAX);
    end else begin
      pix_nxt = pix_q[7:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr1_r        <= 1'b0;
      ev1_r        <= 1'b0;
      ev2_r        <= 1'b0;
      ev3_r        <= 1'b0;
      ev4_r        <= 1'b0;
      ev5_r        <= 1'b0;
      ev6_r        <= 1'b0;
      ev7_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      wr1_r        <= wr1_nxt;
      ev1_r        <= ev1_nxt;
      ev2_r        <= ev1_r;
      ev3_r        <= ev2_r;
      ev4_r        <= ev3_r;
      ev5_r        <= ev4_r;
      ev6_r        <= ev5_r;
      ev7_r        <= ev6_r;
      out_tvalid_r <= ev7_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      widx1_r  <= widx1_nxt;
      wval1_r  <= tbl_val;
      cy1_r    <= cy1_nxt;
      for (int i = 0; i < 2; i++) begin
        t1_r[i]    <= t1_nxt[i];
        t2_r[i]    <= t1_r[i];
        tp2_r[i]   <= tp2_nxt[i];
        sq2_r[i]   <= sq2_nxt[i];
        s2_3_r[i]  <= s2_3_nxt[i];
        cube3_r[i] <= cube3_nxt[i];
        pl4_r[i]   <= pl4_nxt[i];
        ph4_r[i]   <= ph4_nxt[i];
        fu5_r[i]   <= fu5_nxt[i];
      end
      for (int k = 0; k < 4; k++) begin
        n3_r[k] <= n3_nxt[k];
        n4_r[k] <= n3_r[k];
        n5_r[k] <= n4_r[k];
      end
      lo6_r     <= lo6_nxt;
      hi6_r     <= hi6_nxt;
      fv6_r     <= fu5_r[1];
      noise7_r  <= noise7_nxt;
      noise_o_r <= noise7_r;
      pix_o_r   <= pix_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {pix_o_r, noise_o_r};

`include "perlin_noise_2d_macros.svh"

  `PN_ASSERT_NXT(a_ev_to_out, ev7_r && en, out_tvalid_r, "evaluate beat lost before output")
  `PN_ASSERT_NOW(a_out_src, $rose(out_tvalid_r), $past(ev7_r), "output without evaluate beat")
  `PN_ASSERT_NOW(a_pix_sign, out_tvalid_r && (pix_o_r != '0), !noise_o_r[15] && (noise_o_r != '0), "pixel set for non-positive noise")
  `PN_ASSERT_NOW(a_kind_excl, 1'b1, $onehot0({wr1_r, ev1_r}), "load and evaluate in one stage")

endmodule

`default_nettype wire

// ===== bench/perlin_noise_2d_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for perlin_noise_2d: loads the permutation table, then drives
// directed, random and back-pressure beats, checked against an in-bench noise predictor.
// Depends on pn2d_pkg and the perlin_noise_2d RTL.

module perlin_noise_2d_test
  import pn2d_pkg::*;
;

  localparam int TABLE_SIZE   = 256;
  localparam int FRAC_BITS    = 12;
  localparam int FRAC_MASK    = (1 << FRAC_BITS) - 1;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic [7:0] pixel_byte;
    noise_t     noise_value;
  } noise_sample_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [7:0]    perm_shadow [TABLE_SIZE];
  noise_sample_t pending_samples [$];

  int in_gap_max   = 0;
  int out_gap_max  = 0;
  int hold_cycles  = 0;
  int loads_sent   = 0;
  int evals_sent   = 0;
  int samples_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  perlin_noise_2d #(
    .TABLE_SIZE(TABLE_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint frac_to_q14(input int f);
    if (FRAC_BITS >= Q_BITS) begin
      return longint'(f >> (FRAC_BITS - Q_BITS));
    end
    return longint'(f) << (Q_BITS - FRAC_BITS);
  endfunction

  function automatic longint ease_q14(input longint t);
    longint s1;
    longint s2;
    s1 = FADE_A * t - FADE_B * Q_ONE;
    s2 = ((t * s1) >>> Q_BITS) + FADE_C * Q_ONE;
    if (s2 < 0) begin
      s2 = 0;
    end
    return (t * t * t * s2) >>> 42;
  endfunction

  function automatic longint blend_q14(input longint t, input longint a, input longint b);
    return a + ((t * (b - a)) >>> Q_BITS);
  endfunction

  function automatic longint grad_dot(input logic [3:0] h, input longint gx, input longint gy);
    longint gu;
    longint gv;
    gu = (h < H_U_FROM_Y) ? gx : gy;
    if (h < H_V_FROM_Y) begin
      gv = gy;
    end else if (h == H_V_X_LO || h == H_V_X_HI) begin
      gv = gx;
    end else begin
      gv = 0;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  function automatic noise_sample_t predict_noise(input logic [19:0] xc, input logic [19:0] yc);
    int            cx;
    int            cy;
    int            ha;
    int            hb;
    longint        fx;
    longint        fy;
    longint        ex;
    longint        ey;
    longint        n0;
    longint        n1;
    longint        n2;
    longint        n3;
    longint        nz;
    longint        px;
    noise_sample_t r;
    cx = int'(xc >> FRAC_BITS) % TABLE_SIZE;
    cy = int'(yc >> FRAC_BITS) % TABLE_SIZE;
    fx = frac_to_q14(int'(xc) & FRAC_MASK);
    fy = frac_to_q14(int'(yc) & FRAC_MASK);
    ex = ease_q14(fx);
    ey = ease_q14(fy);
    ha = int'(perm_shadow[cx]) + cy;
    hb = int'(perm_shadow[(cx + 1) % TABLE_SIZE]) + cy;
    n0 = grad_dot(perm_shadow[ha % TABLE_SIZE][3:0], fx, fy);
    n1 = grad_dot(perm_shadow[hb % TABLE_SIZE][3:0], fx - Q_ONE, fy);
    n2 = grad_dot(perm_shadow[(ha + 1) % TABLE_SIZE][3:0], fx, fy - Q_ONE);
    n3 = grad_dot(perm_shadow[(hb + 1) % TABLE_SIZE][3:0], fx - Q_ONE, fy - Q_ONE);
    nz = blend_q14(ey, blend_q14(ex, n0, n1), blend_q14(ex, n2, n3));
    if (nz > NOISE_MAX) begin
      nz = NOISE_MAX;
    end
    if (nz < NOISE_MIN) begin
      nz = NOISE_MIN;
    end
    if (nz <= 0) begin
      px = 0;
    end else begin
      px = (nz * PIX_MAX) >>> Q_BITS;
      if (px > PIX_MAX) begin
        px = PIX_MAX;
      end
    end
    r.noise_value = noise_t'(nz);
    r.pixel_byte  = px[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drive / check

  task automatic send_beat(input logic act, input logic [7:0] idx, input logic [7:0] val,
                           input logic [19:0] xc, input logic [19:0] yc);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {yc, xc, val, idx};
    do @(posedge clk); while (!in_tready);
    if (act == ACT_LOAD) begin
      perm_shadow[idx % TABLE_SIZE] = val;
      loads_sent++;
    end else begin
      pending_samples.push_back(predict_noise(xc, yc));
      evals_sent++;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_sample(input logic [23:0] beat);
    noise_sample_t want;
    if (pending_samples.size() == 0) begin
      $error("result beat %h arrived with nothing pending", beat);
      mismatches++;
      return;
    end
    want = pending_samples.pop_front();
    samples_seen++;
    if (beat[15:0] !== want.noise_value) begin
      $error("noise_value: expected %0d, got %0d", want.noise_value, $signed(beat[15:0]));
      mismatches++;
    end
    if (beat[23:16] !== want.pixel_byte) begin
      $error("pixel_byte: expected %0d, got %0d", want.pixel_byte, beat[23:16]);
      mismatches++;
    end
  endtask

  function automatic logic [19:0] rand_coord();
    logic [19:0] c;
    c = 20'($urandom);
    case ($urandom_range(0, 7))
      0:       c[FRAC_BITS-1:0] = '0;
      1:       c[FRAC_BITS-1:0] = '1;
      default: ;
    endcase
    return c;
  endfunction

  // result side: per-beat random stall, plus a long hold when asked
  initial begin : result_monitor
    int stall;
    @(posedge clk iff rst_n);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      stall = 0;
      if (out_tvalid && out_tready) begin
        check_sample(out_tdata);
        stall = $urandom_range(0, out_gap_max);
      end
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic run_table_fill();
    in_gap_max  = 2;
    out_gap_max = 2;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      send_beat(ACT_LOAD, 8'(i), 8'($urandom_range(0, 255)), rand_coord(), rand_coord());
    end
    drain();
  endtask

  task automatic run_directed();
    in_gap_max  = 4;
    out_gap_max = 4;
    // table field extremes; coordinates ignored on a load
    send_beat(ACT_LOAD, 8'h00, 8'h00, 20'hFFFFF, 20'hFFFFF);
    send_beat(ACT_LOAD, 8'hFF, 8'hFF, 20'h00000, 20'h00000);
    // coordinate extremes; table fields ignored on an evaluate
    send_beat(ACT_EVAL, 8'hFF, 8'hFF, 20'h00000, 20'h00000);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'hFFFFF, 20'hFFFFF);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'hFF000, 20'h00000);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h00000, 20'hFF800);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h00800, 20'h00800);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h00001, 20'h00FFF);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h7FFFF, 20'h80001);
    // cell (10,20) centre with all corners pointing inwards: noise +1.0, pixel 255
    send_beat(ACT_LOAD, 8'd10,  8'd100, 20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd11,  8'd150, 20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd120, 8'd0,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd170, 8'd1,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd121, 8'd2,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd171, 8'd3,   20'h0, 20'h0);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h0A800, 20'h14800);
    // same cell, gradients reversed: noise -1.0, pixel zero
    send_beat(ACT_LOAD, 8'd120, 8'd3,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd170, 8'd2,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd121, 8'd1,   20'h0, 20'h0);
    send_beat(ACT_LOAD, 8'd171, 8'd0,   20'h0, 20'h0);
    send_beat(ACT_EVAL, 8'h00, 8'h00, 20'h0A800, 20'h14800);
    // hash index ha + 1 wraps past the table end
    send_beat(ACT_LOAD, 8'd30, 8'd255, 20'h0, 20'h0);
    send_beat(ACT_EVAL, 8'h00, 8'h00, {8'd30, 12'($urandom)}, {8'd0, 12'($urandom)});
    drain();
  endtask

  task automatic run_random_mix();
    int in_max [4]  = '{16, 0, 16, 0};
    int out_max [4] = '{16, 0, 0, 16};
    for (int p = 0; p < 4; p++) begin
      in_gap_max  = in_max[p];
      out_gap_max = out_max[p];
      repeat (100) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(ACT_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    rand_coord(), rand_coord());
        end else begin
          send_beat(ACT_EVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    rand_coord(), rand_coord());
        end
      end
    end
    drain();
  endtask

  task automatic run_back_pressure();
    in_gap_max  = 0;
    out_gap_max = 0;
    hold_cycles = 300;
    repeat (40) begin
      send_beat(ACT_EVAL, 8'h00, 8'h00, rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_table_fill();
    run_directed();
    run_random_mix();
    run_back_pressure();
    if (pending_samples.size() != 0) begin
      $error("%0d noise results never arrived", pending_samples.size());
      mismatches++;
    end
    $display("Table loads: %0d, noise evaluations: %0d, results checked: %0d",
             loads_sent, evals_sent, samples_seen);
    $display("Stimulus spanned gap/stall mixes and a long output hold; mismatches: %0d",
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pn2d_pkg.sv
src/pn2d_ram.sv
src/perlin_noise_2d.sv
bench/perlin_noise_2d_test.sv
